// File: src/qps_pkg.sv
// ----------------------------------------------------------------------------
// Queen placement search package
// Board geometry constants and the layout of a stored queen entry.
// ----------------------------------------------------------------------------
package qps_pkg;

    localparam int HW_SIDE      = 8;
    localparam int MAX_SIDE_DEF = 8;
    localparam int ROW_W        = 4;
    localparam int COL_W        = 3;
    localparam int POS_W        = 3;
    localparam int ENTRY_W      = 2 * POS_W;
    localparam int MASK_W       = HW_SIDE;

endpackage

// File: src/qps_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module qps_ram #(
    parameter int DATA_W = qps_pkg::ENTRY_W,
    parameter int DEPTH  = qps_pkg::HW_SIDE,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/queen_placement_search_core.sv
// Operation: a request runs a data-dependent backtracking search; every board row
//   tried costs one pass over the placed queens in the position RAM, and each result
//   beat then costs one more pass over them. One request is handled at a time; the
//   next is taken after the last result beat is loaded. Reset clears the control
//   state; the RAM is not cleared.
// ----------------------------------------------------------------------------
// Queen placement search core
// Depth-first search for non-attacking queens, with one result beat per row, or a single miss beat if none is found.
// ----------------------------------------------------------------------------
module queen_placement_search_core #(
    parameter int MAX_SIDE = qps_pkg::MAX_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // board_size[3:0], queen_count[7:4]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // row_index[2:0], row_queens[10:3], row_open[18:11]
    output logic        m_axis_tuser,   // found[0]
    output logic        m_axis_tlast
);

    localparam int CAP    = (MAX_SIDE < qps_pkg::HW_SIDE) ? MAX_SIDE : qps_pkg::HW_SIDE;
    localparam int ADDR_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int ROW_W  = qps_pkg::ROW_W;
    localparam int COL_W  = qps_pkg::COL_W;
    localparam int POS_W  = qps_pkg::POS_W;
    localparam int MASK_W = qps_pkg::MASK_W;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_SCAN_START = 3'd1;
    localparam logic [2:0] S_SCAN       = 3'd2;
    localparam logic [2:0] S_CHOOSE     = 3'd3;
    localparam logic [2:0] S_BACK       = 3'd4;
    localparam logic [2:0] S_BACK_WAIT  = 3'd5;
    localparam logic [2:0] S_EMIT       = 3'd6;
    localparam logic [2:0] S_MISS       = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [ROW_W-1:0]  r_side, n_side;
    logic [ROW_W-1:0]  r_n, n_n;
    logic [ROW_W-1:0]  r_depth, n_depth;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [POS_W-1:0]  r_k, n_k;
    logic [MASK_W-1:0] r_amask, n_amask;
    logic [MASK_W-1:0] r_qmask, n_qmask;
    logic              r_mode_out, n_mode_out;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_out_row, n_out_row;
    logic [MASK_W-1:0] r_out_q, n_out_q;
    logic [MASK_W-1:0] r_out_o, n_out_o;
    logic              r_out_found, n_out_found;
    logic              r_out_last, n_out_last;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [qps_pkg::ENTRY_W-1:0] ram_wdata;
    logic [qps_pkg::ENTRY_W-1:0] ram_rdata;

    logic [3:0]        in_side;
    logic [3:0]        in_n;
    logic [3:0]        side_c;
    logic [8:0]        side_full;
    logic [MASK_W-1:0] side_mask;
    logic [MASK_W-1:0] free_mask;
    logic              free_any;
    logic [COL_W-1:0]  pick;
    logic [POS_W-1:0]  qr;
    logic [POS_W-1:0]  qc;
    logic [POS_W-1:0]  rr;
    logic [POS_W-1:0]  dr;
    logic [3:0]        right_col;
    logic [MASK_W-1:0] hit_mask;
    logic [MASK_W-1:0] hit_queen;
    logic              prune;
    logic              out_free;

    qps_ram #(
        .DATA_W (qps_pkg::ENTRY_W),
        .DEPTH  (CAP),
        .ADDR_W (ADDR_W)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_side = s_axis_tdata[3:0];
    assign in_n    = s_axis_tdata[7:4];

    always_comb begin
        if (in_side == 4'd0) begin
            side_c = 4'd1;
        end else if (in_side > 4'(CAP)) begin
            side_c = 4'(CAP);
        end else begin
            side_c = in_side;
        end
    end

    assign side_full = (9'd1 << r_side) - 9'd1;
    assign side_mask = side_full[MASK_W-1:0];
    assign free_mask = ~r_amask & side_mask & (8'hFF << r_col);
    assign free_any  = |free_mask;

    always_comb begin
        pick = '0;
        for (int j = MASK_W - 1; j >= 0; j--) begin
            if (free_mask[j]) begin
                pick = COL_W'(j);
            end
        end
    end

    assign qr = ram_rdata[2*POS_W-1:POS_W];
    assign qc = ram_rdata[POS_W-1:0];
    assign rr = r_row[POS_W-1:0];
    assign dr = (rr > qr) ? (rr - qr) : (qr - rr);
    assign right_col = {1'b0, qc} + {1'b0, dr};

    always_comb begin
        if (qr == rr) begin
            hit_mask  = '1;
            hit_queen = 8'd1 << qc;
        end else begin
            hit_mask  = 8'd1 << qc;
            hit_queen = '0;
            if (right_col < 4'd8) begin
                hit_mask = hit_mask | (8'd1 << right_col[2:0]);
            end
            if (qc >= dr) begin
                hit_mask = hit_mask | (8'd1 << (qc - dr));
            end
        end
    end

    assign prune = ({1'b0, r_row} == {1'b0, r_side})
                || (({1'b0, r_n} + {1'b0, r_row}) > ({1'b0, r_side} + {1'b0, r_depth}));

    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        case (r_state)
            S_SCAN:  ram_raddr = ADDR_W'(r_k + 3'd1);
            S_BACK:  ram_raddr = ADDR_W'(r_depth - 4'd1);
            default: ram_raddr = '0;
        endcase
    end

    assign ram_we    = (r_state == S_CHOOSE) && !r_mode_out && free_any;
    assign ram_waddr = ADDR_W'(r_depth);
    assign ram_wdata = {rr, pick};

    always_comb begin
        n_state     = r_state;
        n_side      = r_side;
        n_n         = r_n;
        n_depth     = r_depth;
        n_row       = r_row;
        n_col       = r_col;
        n_k         = r_k;
        n_amask     = r_amask;
        n_qmask     = r_qmask;
        n_mode_out  = r_mode_out;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_row   = r_out_row;
        n_out_q     = r_out_q;
        n_out_o     = r_out_o;
        n_out_found = r_out_found;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_side     = side_c;
                    n_n        = in_n;
                    n_depth    = '0;
                    n_row      = '0;
                    n_col      = '0;
                    n_mode_out = (in_n == 4'd0);
                    if (in_n > side_c) begin
                        n_state = S_MISS;
                    end else begin
                        n_state = S_SCAN_START;
                    end
                end
            end
            S_SCAN_START: begin
                n_amask = '0;
                n_qmask = '0;
                n_k     = '0;
                if (!r_mode_out && prune) begin
                    n_state = S_BACK;
                end else if (r_depth == 4'd0) begin
                    n_state = r_mode_out ? S_EMIT : S_CHOOSE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_amask = r_amask | hit_mask;
                n_qmask = r_qmask | hit_queen;
                if (({1'b0, r_k} + 4'd1) < r_depth) begin
                    n_k = r_k + 3'd1;
                end else begin
                    n_state = r_mode_out ? S_EMIT : S_CHOOSE;
                end
            end
            S_CHOOSE: begin
                if (free_any) begin
                    n_depth = r_depth + 4'd1;
                    if ((r_depth + 4'd1) == r_n) begin
                        n_mode_out = 1'b1;
                        n_row      = '0;
                    end else if (({1'b0, pick} + 4'd1) == r_side) begin
                        n_row = r_row + 4'd1;
                        n_col = '0;
                    end else begin
                        n_col = pick + 3'd1;
                    end
                end else begin
                    n_row = r_row + 4'd1;
                    n_col = '0;
                end
                n_state = S_SCAN_START;
            end
            S_BACK: begin
                if (r_depth == 4'd0) begin
                    n_state = S_MISS;
                end else begin
                    n_state = S_BACK_WAIT;
                end
            end
            S_BACK_WAIT: begin
                n_depth = r_depth - 4'd1;
                if (({1'b0, qc} + 4'd1) == r_side) begin
                    n_row = {1'b0, qr} + 4'd1;
                    n_col = '0;
                end else begin
                    n_row = {1'b0, qr};
                    n_col = qc + 3'd1;
                end
                n_state = S_SCAN_START;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = rr;
                    n_out_q     = r_qmask;
                    n_out_o     = ~r_amask & ~r_qmask & side_mask;
                    n_out_found = 1'b1;
                    n_out_last  = (r_row + 4'd1) == r_side;
                    if ((r_row + 4'd1) == r_side) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + 4'd1;
                        n_state = S_SCAN_START;
                    end
                end
            end
            S_MISS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = '0;
                    n_out_q     = '0;
                    n_out_o     = '0;
                    n_out_found = 1'b0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mode_out  <= 1'b0;
            r_depth     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_mode_out  <= n_mode_out;
            r_depth     <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side      <= n_side;
        r_n         <= n_n;
        r_row       <= n_row;
        r_col       <= n_col;
        r_k         <= n_k;
        r_amask     <= n_amask;
        r_qmask     <= n_qmask;
        r_out_row   <= n_out_row;
        r_out_q     <= n_out_q;
        r_out_o     <= n_out_o;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_o, r_out_q, r_out_row};
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tlast  = r_out_last;

endmodule
